### rtl/core/jadm_pkg.sv
// Shared types, constants and the arctangent table of the arcade drive mixer.
package jadm_pkg;

    // Field and datapath widths that do not depend on the angle precision.
    localparam int STICK_W      = 8;
    localparam int CMD_MAG_W    = 7;
    localparam int R2_W         = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_FRAC  = 24;
    localparam int XY_W         = 35;
    localparam int Z_W          = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int RTA_W       = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIN_BAND  = 4'd1;

    localparam logic             RESET_DRIVE_MODE = 1'b0;
    localparam logic [RTA_W-1:0] RESET_RTA        = 7'd10;

    // Conditioning of small negative y values in single-stick mode.
    localparam logic signed [STICK_W-1:0] Y_MIRROR_LOW  = -8'sd10;
    localparam logic signed [STICK_W-1:0] Y_MIRROR_HIGH = -8'sd1;
    localparam logic signed [STICK_W-1:0] Y_DEAD_LOW    = -8'sd15;
    localparam logic signed [STICK_W-1:0] Y_DEAD_HIGH   = -8'sd11;

    // Ninety degrees with the CORDIC fraction.
    localparam logic signed [Z_W-1:0] Z_TOP = 32'sd1509949440;

    // Division of a 14-bit product by 90: multiply by ceil(2^20 / 90) and shift.
    // The error stays below 1/90 for every 14-bit value, so the result is exact.
    localparam int                QUOT_W      = 14;
    localparam int                DIV90_SHIFT = 20;
    localparam logic [QUOT_W-1:0] DIV90_MUL   = 14'd11651;

    // Quadrant code as {y negative, x negative}.
    typedef enum logic [1:0] {
        QUAD_UP_RIGHT   = 2'b00,
        QUAD_UP_LEFT    = 2'b01,
        QUAD_DOWN_RIGHT = 2'b10,
        QUAD_DOWN_LEFT  = 2'b11
    } quad_t;

    // Per-sample information that travels alongside the arithmetic.
    typedef struct packed {
        logic                       yneg;
        logic                       xneg;
        logic                       ax_zero;
        logic                       ay_zero;
        logic signed [STICK_W-1:0]  raw_y;
        logic signed [STICK_W-1:0]  left_y;
    } side_t;

    // CORDIC vectoring state.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // atan(2^-i) in degrees with 24 fractional bits.
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 32'sd754974720;
            5'd1:    val = 32'sd445687602;
            5'd2:    val = 32'sd235489088;
            5'd3:    val = 32'sd119537938;
            5'd4:    val = 32'sd60000934;
            5'd5:    val = 32'sd30029717;
            5'd6:    val = 32'sd15018523;
            5'd7:    val = 32'sd7509720;
            5'd8:    val = 32'sd3754917;
            5'd9:    val = 32'sd1877466;
            5'd10:   val = 32'sd938734;
            5'd11:   val = 32'sd469367;
            5'd12:   val = 32'sd234684;
            5'd13:   val = 32'sd117342;
            5'd14:   val = 32'sd58671;
            5'd15:   val = 32'sd29335;
            5'd16:   val = 32'sd14668;
            5'd17:   val = 32'sd7334;
            5'd18:   val = 32'sd3667;
            5'd19:   val = 32'sd1833;
            5'd20:   val = 32'sd917;
            5'd21:   val = 32'sd458;
            5'd22:   val = 32'sd229;
            5'd23:   val = 32'sd115;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### rtl/core/jadm_cell.sv
// One cell of the chain: a CORDIC vectoring step and, in the first cells, a square root digit.
module jadm_cell #(
    parameter int STAGE    = 0,
    parameter int RAD_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       valid_in,
    input  jadm_pkg::side_t            side_in,
    input  jadm_pkg::cordic_t          cord_in,
    input  logic [jadm_pkg::R2_W-1:0]  r2_in,
    input  logic [RAD_BITS+1:0]        rem_in,
    input  logic [RAD_BITS-1:0]        root_in,
    output logic                       valid_out,
    output jadm_pkg::side_t            side_out,
    output jadm_pkg::cordic_t          cord_out,
    output logic [jadm_pkg::R2_W-1:0]  r2_out,
    output logic [RAD_BITS+1:0]        rem_out,
    output logic [RAD_BITS-1:0]        root_out
);
    import jadm_pkg::*;

    localparam int REM_W = RAD_BITS + 2;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   y_pos;
    cordic_t                cord_next;
    logic [REM_W-1:0]       rem_next;
    logic [RAD_BITS-1:0]    root_next;

    logic                   valid_reg;
    side_t                  side_reg;
    cordic_t                cord_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [RAD_BITS-1:0]    root_reg;

    // CORDIC vectoring step: rotate towards the x axis by atan(2^-STAGE).
    always_comb begin
        xs    = cord_in.x >>> STAGE;
        ys    = cord_in.y >>> STAGE;
        y_pos = !cord_in.y[XY_W-1] && (cord_in.y != '0);
        if (y_pos) begin
            cord_next.x = cord_in.x + ys;
            cord_next.y = cord_in.y - xs;
            cord_next.z = cord_in.z + atan_deg(5'(STAGE));
        end else begin
            cord_next.x = cord_in.x - ys;
            cord_next.y = cord_in.y + xs;
            cord_next.z = cord_in.z - atan_deg(5'(STAGE));
        end
    end

    // Restoring square root digit; the radicand's low pairs are all zero.
    if (STAGE < RAD_BITS) begin : g_sqrt
        logic [1:0]       pair;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        if (STAGE < R2_W / 2) begin : g_pair
            assign pair = r2_in[R2_W-1-2*STAGE -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], pair};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[RAD_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[RAD_BITS-2:0], 1'b0};
            end
        end
    end else begin : g_hold
        assign rem_next  = rem_in;
        assign root_next = root_in;
    end

    // Valid flag of the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    // Payload of the cell.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_in;
            cord_reg <= cord_next;
            r2_reg   <= r2_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign cord_out  = cord_reg;
    assign r2_out    = r2_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

### rtl/core/jadm_tail.sv
// Back end of the mixer: saturation, angle rounding, proportional side and quadrant selection.
module jadm_tail #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                valid_in,
    input  jadm_pkg::side_t                     side_in,
    input  logic signed [jadm_pkg::Z_W-1:0]     z_in,
    input  logic [ANGLE_FRAC_BITS+7:0]          root_in,
    input  logic                                drive_mode,
    input  logic [jadm_pkg::RTA_W-1:0]          spin_band,
    output logic                                m_valid,
    output logic signed [jadm_pkg::STICK_W-1:0] m_left_cmd,
    output logic signed [jadm_pkg::STICK_W-1:0] m_right_cmd
);
    import jadm_pkg::*;

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int AW    = CMD_MAG_W + F;
    localparam int RB    = CMD_MAG_W + 1 + F;
    localparam int PW    = 2 * AW;
    localparam int MW    = 2 * QUOT_W;
    localparam int SHIFT = CORDIC_FRAC - F;

    localparam logic [RB-1:0] RAD_MAX     = RB'(127) << F;
    localparam logic [AW-1:0] RAD_MAX_A   = AW'(127) << F;
    localparam logic [AW-1:0] ANGLE_RIGHT = AW'(90) << F;
    localparam logic [31:0]   ROUND_HALF  = 32'(1) << (SHIFT - 1);

    logic signed [Z_W-1:0]          z_clamped;
    logic [31:0]                    z_rounded;
    logic [AW-1:0]                  rad_next;
    logic [AW-1:0]                  angle_next;
    logic                           spin_next;
    logic [PW-1:0]                  prod_next;
    logic [MW-1:0]                  quot_full;
    logic [CMD_MAG_W-1:0]           p_next;
    logic signed [STICK_W-1:0]      r_pos;
    logic signed [STICK_W-1:0]      p_pos;
    logic signed [STICK_W-1:0]      left_next;
    logic signed [STICK_W-1:0]      right_next;
    quad_t                          quad;

    logic                           t1_valid_reg;
    side_t                          t1_side_reg;
    logic [AW-1:0]                  rad_reg;
    logic [AW-1:0]                  angle_reg;

    logic                           t2_valid_reg;
    side_t                          t2_side_reg;
    logic                           t2_spin_reg;
    logic [CMD_MAG_W-1:0]           t2_ri_reg;
    logic [PW-1:0]                  prod_reg;

    logic                           t3_valid_reg;
    side_t                          t3_side_reg;
    logic                           t3_spin_reg;
    logic [CMD_MAG_W-1:0]           ri_reg;
    logic [CMD_MAG_W-1:0]           p_reg;

    logic                           m_valid_reg;
    logic signed [STICK_W-1:0]      left_reg;
    logic signed [STICK_W-1:0]      right_reg;

    // First stage: saturate the radius, clamp and round the angle, handle the axes.
    always_comb begin
        if (root_in > RAD_MAX) begin
            rad_next = RAD_MAX_A;
        end else begin
            rad_next = AW'(root_in);
        end
        if (z_in[Z_W-1]) begin
            z_clamped = '0;
        end else if (z_in > Z_TOP) begin
            z_clamped = Z_TOP;
        end else begin
            z_clamped = z_in;
        end
        z_rounded = $unsigned(z_clamped) + ROUND_HALF;
        if (side_in.ay_zero) begin
            angle_next = '0;
        end else if (side_in.ax_zero) begin
            angle_next = ANGLE_RIGHT;
        end else begin
            angle_next = AW'(z_rounded >> SHIFT);
        end
    end

    // Second stage: spin decision and radius times angle.
    always_comb begin
        spin_next = angle_reg < {spin_band, {F{1'b0}}};
        prod_next = PW'(rad_reg) * PW'(angle_reg);
    end

    // Third stage: divide by 90 degrees in the angle and radius scale.
    always_comb begin
        quot_full = MW'(prod_reg[PW-1:2*F]) * MW'(DIV90_MUL);
        p_next    = quot_full[DIV90_SHIFT +: CMD_MAG_W];
    end

    // Fourth stage: full and proportional side by quadrant; tank mode passes the sticks.
    always_comb begin
        r_pos = $signed({1'b0, ri_reg});
        p_pos = $signed({1'b0, p_reg});
        quad  = quad_t'({t3_side_reg.yneg, t3_side_reg.xneg});
        if (drive_mode) begin
            left_next  = t3_side_reg.left_y;
            right_next = t3_side_reg.raw_y;
        end else begin
            case (quad)
                QUAD_UP_RIGHT: begin
                    left_next  = r_pos;
                    right_next = t3_spin_reg ? -r_pos : p_pos;
                end
                QUAD_UP_LEFT: begin
                    right_next = r_pos;
                    left_next  = t3_spin_reg ? -r_pos : p_pos;
                end
                QUAD_DOWN_RIGHT: begin
                    left_next  = -r_pos;
                    right_next = t3_spin_reg ? r_pos : -p_pos;
                end
                QUAD_DOWN_LEFT: begin
                    right_next = -r_pos;
                    left_next  = t3_spin_reg ? r_pos : -p_pos;
                end
                default: begin
                    left_next  = '0;
                    right_next = '0;
                end
            endcase
        end
    end

    // Valid flags of the stages and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            t1_valid_reg <= valid_in;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            m_valid_reg  <= t3_valid_reg;
        end
    end

    // Payload of the stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_side_reg <= side_in;
            rad_reg     <= rad_next;
            angle_reg   <= angle_next;
            t2_side_reg <= t1_side_reg;
            t2_spin_reg <= spin_next;
            t2_ri_reg   <= rad_reg[AW-1:F];
            prod_reg    <= prod_next;
            t3_side_reg <= t2_side_reg;
            t3_spin_reg <= t2_spin_reg;
            ri_reg      <= t2_ri_reg;
            p_reg       <= p_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_cmd  = left_reg;
    assign m_right_cmd = right_reg;

    a_rad_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        t1_valid_reg |-> rad_reg <= RAD_MAX_A)
        else $error("Radius above the saturation limit.");

    a_angle_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        t1_valid_reg |-> angle_reg <= ANGLE_RIGHT)
        else $error("Reduced angle above ninety degrees.");

    a_prop_below_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        t3_valid_reg |-> p_reg <= ri_reg)
        else $error("Proportional side exceeds the radius.");

endmodule

### rtl/core/joystick_arcade_drive_mixer.sv
// Top level of the arcade drive mixer: configuration, input conditioning and the cell chain.
//
// The block turns one joystick sample per transaction into a left and a right drive command.
// Samples arrive on the s_ channel (s_valid, s_ready, s_stick_x, s_stick_y, s_stick_left_y)
// and results leave on the m_ channel (m_valid, m_ready, m_left_cmd, m_right_cmd), one
// result for every sample, in order. The cfg_ channel writes drive_mode (index 0) and
// the spin band in degrees (index 1); other indexes are ignored. It is always ready; the user
// must write it only while no sample is in flight, which the block itself does not enforce.
// A sample accepted at a clock edge passes through one input stage, a chain of 24 cells that
// each do one CORDIC step (the first 16 also one square root digit) and four back-end stages
// before its result shows on m_valid. The pipeline accepts one sample per cycle while not stalled.
// The whole pipeline advances together; while a result waits on a low m_ready, s_ready is
// low and every stage holds its contents.
// Reset clears all valid flags, sets drive_mode to single-stick and the spin band to
// ten degrees.
module joystick_arcade_drive_mixer #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [jadm_pkg::STICK_W-1:0]     s_stick_x,
    input  logic signed [jadm_pkg::STICK_W-1:0]     s_stick_y,
    input  logic signed [jadm_pkg::STICK_W-1:0]     s_stick_left_y,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [jadm_pkg::STICK_W-1:0]     m_left_cmd,
    output logic signed [jadm_pkg::STICK_W-1:0]     m_right_cmd,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [jadm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [jadm_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import jadm_pkg::*;

    localparam int RB    = CMD_MAG_W + 1 + ANGLE_FRAC_BITS;
    localparam int REM_W = RB + 2;
    localparam int X_PAD = XY_W - STICK_W - CORDIC_FRAC;

    logic                       adv;
    logic                       drive_mode_reg;
    logic [RTA_W-1:0]           rta_reg;

    logic signed [STICK_W-1:0]  y_cond;
    logic [STICK_W-1:0]         ax;
    logic [STICK_W-1:0]         ay;
    side_t                      side_next;
    cordic_t                    cord_next;
    logic [R2_W-1:0]            r2_next;

    logic                       in_valid_reg;
    side_t                      in_side_reg;
    cordic_t                    in_cord_reg;
    logic [R2_W-1:0]            in_r2_reg;

    logic                       valid_w [CORDIC_STEPS+1];
    side_t                      side_w  [CORDIC_STEPS+1];
    cordic_t                    cord_w  [CORDIC_STEPS+1];
    logic [R2_W-1:0]            r2_w    [CORDIC_STEPS+1];
    logic [REM_W-1:0]           rem_w   [CORDIC_STEPS+1];
    logic [RB-1:0]              root_w  [CORDIC_STEPS+1];

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg <= RESET_DRIVE_MODE;
            rta_reg        <= RESET_RTA;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_DRIVE_MODE) begin
                drive_mode_reg <= cfg_data[0];
            end else if (cfg_index == REG_SPIN_BAND) begin
                rta_reg <= cfg_data[RTA_W-1:0];
            end
        end
    end

    // Input conditioning: mirror small negative y, zero a slightly larger one, take magnitudes.
    always_comb begin
        if (s_stick_y inside {[Y_MIRROR_LOW:Y_MIRROR_HIGH]}) begin
            y_cond = -s_stick_y;
        end else if (s_stick_y inside {[Y_DEAD_LOW:Y_DEAD_HIGH]}) begin
            y_cond = '0;
        end else begin
            y_cond = s_stick_y;
        end
        ax = s_stick_x[STICK_W-1] ? STICK_W'(-s_stick_x) : STICK_W'(s_stick_x);
        ay = y_cond[STICK_W-1] ? STICK_W'(-y_cond) : STICK_W'(y_cond);

        side_next.yneg    = y_cond[STICK_W-1];
        side_next.xneg    = s_stick_x[STICK_W-1];
        side_next.ax_zero = (ax == '0);
        side_next.ay_zero = (ay == '0);
        side_next.raw_y   = s_stick_y;
        side_next.left_y  = s_stick_left_y;

        cord_next.x = $signed({{X_PAD{1'b0}}, ax, {CORDIC_FRAC{1'b0}}});
        cord_next.y = $signed({{X_PAD{1'b0}}, ay, {CORDIC_FRAC{1'b0}}});
        cord_next.z = '0;

        r2_next = R2_W'(ax) * R2_W'(ax) + R2_W'(ay) * R2_W'(ay);
    end

    // Input stage valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_side_reg <= side_next;
            in_cord_reg <= cord_next;
            in_r2_reg   <= r2_next;
        end
    end

    // Head of the chain: the square root starts from an empty remainder and root.
    assign valid_w[0] = in_valid_reg;
    assign side_w[0]  = in_side_reg;
    assign cord_w[0]  = in_cord_reg;
    assign r2_w[0]    = in_r2_reg;
    assign rem_w[0]   = '0;
    assign root_w[0]  = '0;

    // Chain of cells, one CORDIC step each.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        jadm_cell #(
            .STAGE    (i),
            .RAD_BITS (RB)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (valid_w[i]),
            .side_in   (side_w[i]),
            .cord_in   (cord_w[i]),
            .r2_in     (r2_w[i]),
            .rem_in    (rem_w[i]),
            .root_in   (root_w[i]),
            .valid_out (valid_w[i+1]),
            .side_out  (side_w[i+1]),
            .cord_out  (cord_w[i+1]),
            .r2_out    (r2_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .root_out  (root_w[i+1])
        );
    end

    // Back end and output register.
    jadm_tail #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_tail (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .adv                (adv),
        .valid_in           (valid_w[CORDIC_STEPS]),
        .side_in            (side_w[CORDIC_STEPS]),
        .z_in               (cord_w[CORDIC_STEPS].z),
        .root_in            (root_w[CORDIC_STEPS]),
        .drive_mode         (drive_mode_reg),
        .spin_band          (rta_reg),
        .m_valid            (m_valid),
        .m_left_cmd         (m_left_cmd),
        .m_right_cmd        (m_right_cmd)
    );

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("Input accepted while the output transaction is stalled.");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result presented right after reset.");

    a_mixed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !drive_mode_reg) |->
            (m_left_cmd != 8'sh80) && (m_right_cmd != 8'sh80))
        else $error("Single-stick command outside the symmetric range.");

endmodule

### tb/tb.sv
// Self-checking testbench for the arcade drive mixer: a scoreboard class and stimulus tasks.
module tb;
    import jadm_pkg::*;

    localparam int ANGLE_FB   = 8;
    localparam int STEP_COUNT = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASE_COUNT = 7;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_REG_INDEX = 4'd9;

    // Arctangent of 2^-i in degrees, 24 fractional bits.
    localparam longint ATAN_DEG_Q24 [STEP_COUNT] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [STICK_W-1:0] left_cmd;
        logic signed [STICK_W-1:0] right_cmd;
    } drive_cmd_t;

    // Holds the mixer's register copy and the queue of drive commands still owed.
    class drive_cmd_scoreboard;
        drive_cmd_t       owed_cmds[$];
        bit               tank_mode;
        bit [RTA_W-1:0]   spin_band;
        int               errors;

        function new();
            tank_mode = RESET_DRIVE_MODE;
            spin_band = RESET_RTA;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DRIVE_MODE)
                tank_mode = data[0];
            else if (idx == REG_SPIN_BAND)
                spin_band = data[RTA_W-1:0];
        endfunction

        // Bitwise integer square root.
        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // First-quadrant angle of (ax, ay) in degrees with ANGLE_FB fractional bits.
        function longint first_quad_angle(int ax, int ay);
            longint cx, cy, z, xs, ys, top;
            top = longint'(90) << 24;
            z   = 0;
            if (ay == 0)
                return 0;
            if (ax == 0)
                return longint'(90) << ANGLE_FB;
            cx = longint'(ax) << 24;
            cy = longint'(ay) << 24;
            for (int i = 0; i < STEP_COUNT; i++) begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (cy > 0) begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z  = z + ATAN_DEG_Q24[i];
                end else begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z  = z - ATAN_DEG_Q24[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > top)
                z = top;
            return (z + (longint'(1) << (23 - ANGLE_FB))) >>> (24 - ANGLE_FB);
        endfunction

        // Drive commands for one joystick sample under the current registers.
        function drive_cmd_t mix(logic signed [STICK_W-1:0] x, logic signed [STICK_W-1:0] y,
                                 logic signed [STICK_W-1:0] ly);
            drive_cmd_t cmd;
            int         xi, yi, ax, ay, ri, pi, lft, rgt;
            longint     rad, ang, prop;
            bit         spin;
            quad_t      quad;
            xi = x;
            yi = y;
            if (tank_mode) begin
                cmd.left_cmd  = ly;
                cmd.right_cmd = y;
                return cmd;
            end
            // Small negative y is mirrored, a little more negative is dead.
            if (yi < 0 && yi >= -10)
                yi = -yi;
            else if (yi < -10 && yi >= -15)
                yi = 0;
            ax = (xi < 0) ? -xi : xi;
            ay = (yi < 0) ? -yi : yi;
            rad = int_sqrt(longint'(ax * ax + ay * ay) << (2 * ANGLE_FB));
            if (rad > (longint'(127) << ANGLE_FB))
                rad = longint'(127) << ANGLE_FB;
            ri   = int'(rad >> ANGLE_FB);
            ang  = first_quad_angle(ax, ay);
            spin = ang < (longint'(spin_band) << ANGLE_FB);
            prop = (rad * ang) / (longint'(90) << (2 * ANGLE_FB));
            pi   = int'(prop);
            // On the negative y axis x is not negative, so it falls to the down-right case.
            quad = quad_t'({yi < 0, xi < 0});
            case (quad)
                QUAD_UP_RIGHT: begin
                    lft = ri;
                    rgt = spin ? -ri : pi;
                end
                QUAD_UP_LEFT: begin
                    rgt = ri;
                    lft = spin ? -ri : pi;
                end
                QUAD_DOWN_RIGHT: begin
                    lft = -ri;
                    rgt = spin ? ri : -pi;
                end
                default: begin
                    rgt = -ri;
                    lft = spin ? ri : -pi;
                end
            endcase
            cmd.left_cmd  = lft[STICK_W-1:0];
            cmd.right_cmd = rgt[STICK_W-1:0];
            return cmd;
        endfunction

        function void note_sample(logic signed [STICK_W-1:0] x, logic signed [STICK_W-1:0] y,
                                  logic signed [STICK_W-1:0] ly);
            owed_cmds.push_back(mix(x, y, ly));
        endfunction

        function void check_result(logic signed [STICK_W-1:0] lft,
                                   logic signed [STICK_W-1:0] rgt);
            drive_cmd_t want;
            if (owed_cmds.size() == 0) begin
                $error("unexpected result transaction: left_cmd %0d right_cmd %0d", lft, rgt);
                errors++;
                return;
            end
            want = owed_cmds.pop_front();
            if (lft !== want.left_cmd) begin
                $error("left_cmd: expected %0d, got %0d", want.left_cmd, lft);
                errors++;
            end
            if (rgt !== want.right_cmd) begin
                $error("right_cmd: expected %0d, got %0d", want.right_cmd, rgt);
                errors++;
            end
        endfunction

        function int pending();
            return owed_cmds.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [STICK_W-1:0]     s_stick_x;
    logic signed [STICK_W-1:0]     s_stick_y;
    logic signed [STICK_W-1:0]     s_stick_left_y;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [STICK_W-1:0]     m_left_cmd;
    logic signed [STICK_W-1:0]     m_right_cmd;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    drive_cmd_scoreboard sb;
    int snd_idle;
    int rcv_idle;
    int cycle_count = 0;

    joystick_arcade_drive_mixer #(
        .ANGLE_FRAC_BITS(ANGLE_FB)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stick_x     (s_stick_x),
        .s_stick_y     (s_stick_y),
        .s_stick_left_y(s_stick_left_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_cmd    (m_left_cmd),
        .m_right_cmd   (m_right_cmd),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a period of 20.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // The result side stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Every result transaction is checked at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready)
            sb.check_result(m_left_cmd, m_right_cmd);
    end

    // One joystick sample; entered and left at a falling edge, valid left high.
    task automatic send_sample(input int x, input int y, input int ly);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_stick_x      <= x[STICK_W-1:0];
        s_stick_y      <= y[STICK_W-1:0];
        s_stick_left_y <= ly[STICK_W-1:0];
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(s_stick_x, s_stick_y, s_stick_left_y);
        @(negedge aclk);
    endtask

    // Stops the sample stream and waits for every owed result.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Random stick value, biased towards the extremes and the conditioned y band.
    function automatic int pick_stick();
        int v;
        case ($urandom_range(7))
            0: begin
                v = $urandom_range(3);
                return (v == 0) ? -128 : (v == 1) ? -127 : (v == 2) ? 127 : 0;
            end
            1: return -int'($urandom_range(16, 1));
            default: return int'($urandom_range(255)) - 128;
        endcase
    endfunction

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_stick_x      = '0;
        s_stick_y      = '0;
        s_stick_left_y = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        snd_idle       = 34;
        rcv_idle       = 77;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed samples under the reset registers: axes, corners, y conditioning, spin.
        send_sample(0, 0, 0);
        send_sample(127, 0, 0);
        send_sample(-128, 0, 0);
        send_sample(0, 127, 0);
        send_sample(0, -128, 0);
        send_sample(0, -1, 0);
        send_sample(0, -10, 0);
        send_sample(0, -11, 0);
        send_sample(0, -15, 0);
        send_sample(0, -16, 0);
        send_sample(127, 127, 0);
        send_sample(-128, -128, 0);
        send_sample(127, -128, 0);
        send_sample(-128, 127, 0);
        send_sample(60, -4, 0);
        send_sample(-60, -13, 0);
        send_sample(100, 12, 0);
        send_sample(-100, -20, 0);
        send_sample(90, -5, 0);
        send_sample(-5, -120, 0);
        hold_until_drained();

        // Tank mode passes both sticks through, including the most negative value.
        write_reg(REG_DRIVE_MODE, 8'd1);
        send_sample(-128, 127, -128);
        send_sample(127, -128, 127);
        send_sample(0, 5, -3);
        hold_until_drained();

        // Random phases, each under its own register setting; the phases share three idle patterns.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    write_reg(UNUSED_REG_INDEX, 8'hFF);
                    write_reg(REG_DRIVE_MODE, 8'd0);
                    write_reg(REG_SPIN_BAND, 8'd10);
                end
                1: write_reg(REG_SPIN_BAND, 8'd0);
                2: write_reg(REG_SPIN_BAND, 8'd90);
                3: write_reg(REG_SPIN_BAND, 8'hFF);
                4: write_reg(REG_DRIVE_MODE, 8'h03);
                5: begin
                    write_reg(REG_DRIVE_MODE, 8'h02);
                    write_reg(REG_SPIN_BAND, CFG_DATA_W'($urandom_range(89, 1)));
                end
                default: write_reg(REG_SPIN_BAND, 8'd45);
            endcase
            if (ph < 2) begin
                snd_idle = 34;
                rcv_idle = 77;
            end else if (ph < 4) begin
                snd_idle = 77;
                rcv_idle = 34;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once, the sender waits mid-phase until the pipeline has emptied.
                if (ph == 1 && k == PHASE_ITEMS / 2)
                    hold_until_drained();
                send_sample(pick_stick(), pick_stick(), int'($urandom_range(255)) - 128);
            end
            hold_until_drained();
        end

        repeat (40) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/jadm_pkg.sv
rtl/core/jadm_cell.sv
rtl/core/jadm_tail.sv
rtl/core/joystick_arcade_drive_mixer.sv
tb/tb.sv
